>>> rtl/assert_macros.svh
// assertion helpers included by adll_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/adll_pkg.sv
`default_nettype none

package adll_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int SLOT_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int OUT_SLOT_W = 4;

    typedef logic [SLOT_W-1:0] t_addr;
    typedef logic [LINK_W-1:0] t_link;

    localparam t_link LINK_NULL = LINK_W'(POOL_DEPTH);

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key_value;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  list_empty;
    } t_rsp;

    // one read address for all three memories, one write port on each
    typedef struct packed {
        t_addr                   rd_addr;
        logic                    next_we;
        t_addr                   next_addr;
        t_link                   next_data;
        logic                    prev_we;
        t_addr                   prev_addr;
        t_link                   prev_data;
        logic                    key_we;
        t_addr                   key_addr;
        logic signed [KEY_W-1:0] key_data;
    } t_mem_req;

    typedef struct packed {
        t_link                   rd_next;
        t_link                   rd_prev;
        logic signed [KEY_W-1:0] rd_key;
    } t_mem_rsp;

    function automatic logic is_slot(input t_link p);
        return p < LINK_NULL;
    endfunction

    function automatic t_addr link_addr(input t_link p);
        return p[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/adll_store.sv
`default_nettype none

module adll_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire adll_pkg::t_mem_req i_req,
    output adll_pkg::t_mem_rsp      o_rsp
);
    import adll_pkg::*;

    t_link                   r_next_mem [POOL_DEPTH];
    t_link                   r_prev_mem [POOL_DEPTH];
    logic signed [KEY_W-1:0] r_key_mem  [POOL_DEPTH];
    logic [POOL_DEPTH-1:0]   r_next_vld;
    t_link                   r_rd_next;
    t_link                   r_rd_prev;
    logic signed [KEY_W-1:0] r_rd_key;

    // an unwritten next link reads as its reset value, the following slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
        end else if (i_req.next_we) begin
            r_next_vld[i_req.next_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.next_we) begin
            r_next_mem[i_req.next_addr] <= i_req.next_data;
        end
        if (i_req.prev_we) begin
            r_prev_mem[i_req.prev_addr] <= i_req.prev_data;
        end
        if (i_req.key_we) begin
            r_key_mem[i_req.key_addr] <= i_req.key_data;
        end
        r_rd_next <= r_next_vld[i_req.rd_addr] ? r_next_mem[i_req.rd_addr]
                                              : LINK_W'(i_req.rd_addr) + LINK_W'(1);
        r_rd_prev <= r_prev_mem[i_req.rd_addr];
        r_rd_key  <= r_key_mem[i_req.rd_addr];
    end

    assign o_rsp.rd_next = r_rd_next;
    assign o_rsp.rd_prev = r_rd_prev;
    assign o_rsp.rd_key  = r_rd_key;

endmodule

`default_nettype wire

>>> rtl/adll_seq.sv
`default_nettype none

module adll_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire adll_pkg::t_cmd     i_cmd,
    input  wire adll_pkg::t_mem_rsp i_mem,
    output adll_pkg::t_mem_req      o_mem,
    output logic                    o_busy,
    output logic                    o_strobe,
    output adll_pkg::t_rsp          o_rsp
);
    import adll_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_WALK,
        S_UNLINK
    } t_state;

    t_state                  r_state,     n_state;
    t_link                   r_list_head, n_list_head;
    t_link                   r_free_head, n_free_head;
    t_addr                   r_cur,       n_cur;
    t_link                   r_steps,     n_steps;
    logic signed [KEY_W-1:0] r_key,       n_key;
    t_link                   r_p,         n_p;
    t_link                   r_n,         n_n;
    logic                    r_strobe,    n_strobe;
    t_rsp                    r_rsp,       n_rsp;
    logic                    key_hit;

    // shared key comparator used at every step of the walk
    assign key_hit = (i_mem.rd_key == r_key);

    always_comb begin
        n_state     = r_state;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_key       = r_key;
        n_p         = r_p;
        n_n         = r_n;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        o_mem       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = i_cmd.key_value;
                    if (i_cmd.func == FN_INSERT) begin
                        if (!is_slot(r_free_head)) begin
                            n_strobe = 1'b1;
                            n_rsp    = '{ST_FULL, '0, !is_slot(r_list_head)};
                        end else begin
                            o_mem.rd_addr = link_addr(r_free_head);
                            // old head points back at the node being taken
                            if (is_slot(r_list_head)) begin
                                o_mem.prev_we   = 1'b1;
                                o_mem.prev_addr = link_addr(r_list_head);
                                o_mem.prev_data = r_free_head;
                            end
                            n_cur   = link_addr(r_free_head);
                            n_state = S_INS;
                        end
                    end else begin
                        if (!is_slot(r_list_head)) begin
                            n_strobe = 1'b1;
                            n_rsp    = '{ST_MISSING, '0, 1'b1};
                        end else begin
                            o_mem.rd_addr = link_addr(r_list_head);
                            n_cur   = link_addr(r_list_head);
                            n_steps = '0;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_INS: begin
                o_mem.next_we   = 1'b1;
                o_mem.next_addr = r_cur;
                o_mem.next_data = r_list_head;
                o_mem.key_we    = 1'b1;
                o_mem.key_addr  = r_cur;
                o_mem.key_data  = r_key;
                o_mem.prev_we   = 1'b1;
                o_mem.prev_addr = r_cur;
                o_mem.prev_data = LINK_NULL;
                n_free_head     = i_mem.rd_next;
                n_list_head     = LINK_W'(r_cur);
                n_strobe        = 1'b1;
                n_rsp           = '{ST_DONE, OUT_SLOT_W'(r_cur), 1'b0};
                n_state         = S_IDLE;
            end
            S_WALK: begin
                if (key_hit) begin
                    // freed node goes onto the free chain right away
                    o_mem.next_we   = 1'b1;
                    o_mem.next_addr = r_cur;
                    o_mem.next_data = r_free_head;
                    n_free_head     = LINK_W'(r_cur);
                    n_p             = i_mem.rd_prev;
                    n_n             = i_mem.rd_next;
                    n_state         = S_UNLINK;
                end else if (!is_slot(i_mem.rd_next) || r_steps == LINK_NULL) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{ST_MISSING, '0, !is_slot(r_list_head)};
                    n_state  = S_IDLE;
                end else begin
                    o_mem.rd_addr = link_addr(i_mem.rd_next);
                    n_cur   = link_addr(i_mem.rd_next);
                    n_steps = r_steps + LINK_W'(1);
                end
            end
            S_UNLINK: begin
                if (is_slot(r_n)) begin
                    o_mem.prev_we   = 1'b1;
                    o_mem.prev_addr = link_addr(r_n);
                    o_mem.prev_data = r_p;
                end
                if (is_slot(r_p)) begin
                    o_mem.next_we   = 1'b1;
                    o_mem.next_addr = link_addr(r_p);
                    o_mem.next_data = r_n;
                end else begin
                    n_list_head = r_n;
                end
                n_strobe = 1'b1;
                n_rsp    = '{ST_DONE, OUT_SLOT_W'(r_cur), !is_slot(r_p) && !is_slot(r_n)};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= LINK_NULL;
            r_free_head <= '0;
            r_steps     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_steps     <= n_steps;
            r_strobe    <= n_strobe;
        end
        r_cur <= n_cur;
        r_key <= n_key;
        r_p   <= n_p;
        r_n   <= n_n;
        r_rsp <= n_rsp;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `ASSERT_IMPLY(a_strobe_idle, r_strobe, r_state == S_IDLE, "result shown while still busy")
    `ASSERT_IMPLY(a_fail_slot_zero, r_strobe && r_rsp.status != ST_DONE, r_rsp.slot == '0,
        "failed transaction reports a nonzero slot")
    `ASSERT_ALWAYS(a_steps_bound, r_steps <= LINK_NULL, "walk ran past the pool depth")
    `ASSERT_ALWAYS(a_link_range, r_free_head <= LINK_NULL && r_list_head <= LINK_NULL,
        "head link out of range")

endmodule

`default_nettype wire

>>> rtl/array_doubly_linked_list.sv
// insert: strobe registered out of S_INS; full: strobe registered straight from idle. delete:
// S_WALK reads one node per cycle through the registered memory read and the shared key
// comparator, for up to POOL_DEPTH steps, then goes to S_UNLINK on a hit or reports not found;
// an empty list gives not found straight from idle. busy falls in the strobe cycle, so the next
// start can follow it. synchronous active-low reset empties the list and threads every slot onto
// the free chain at once through per-entry valid bits; the receiver cannot stall results
`default_nettype none

module array_doubly_linked_list (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire adll_pkg::t_cmd i_cmd,
    output logic                busy,
    output logic                o_strobe,
    output adll_pkg::t_rsp      o_rsp
);
    import adll_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    adll_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_mem    (mem_rsp),
        .o_mem    (mem_req),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    adll_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

endmodule

`default_nettype wire
